// File: design/asi_pkg.sv
// shared types, codes and reset constants for the actuator safety interlock
// no dependencies
`default_nettype none

package asi_pkg;

    localparam int COUNT_WIDTH_DEF = 20;
    localparam int OP_W            = 4;
    localparam int GRAMS_W         = 12;
    localparam int HEADCOUNT_W     = 8;
    localparam int MODE_W          = 3;
    localparam int FEED_RATE_W     = 8;
    localparam int CLEAN_CAP_W     = 20;
    localparam int CFG_IDX_W       = 4;
    localparam int CFG_DATA_W      = 20;
    localparam int FEED_PROD_W     = GRAMS_W + FEED_RATE_W;

    localparam logic [FEED_RATE_W-1:0] FEED_RATE_RST = FEED_RATE_W'(30);
    localparam logic [CLEAN_CAP_W-1:0] CLEAN_CAP_RST = CLEAN_CAP_W'(300000);

    localparam logic [CFG_IDX_W-1:0] CFG_FEED_RATE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_CLEAN_CAP = CFG_IDX_W'(1);

    localparam logic [MODE_W-1:0] MODE_CODE_BOOT = MODE_W'(0);
    localparam logic [MODE_W-1:0] MODE_CODE_CONN = MODE_W'(1);
    localparam logic [MODE_W-1:0] MODE_CODE_IDLE = MODE_W'(2);
    localparam logic [MODE_W-1:0] MODE_CODE_RUN  = MODE_W'(3);
    localparam logic [MODE_W-1:0] MODE_CODE_ERR  = MODE_W'(4);
    localparam logic [MODE_W-1:0] MODE_CODE_STOP = MODE_W'(5);

    typedef enum logic [OP_W-1:0] {
        OP_TICK        = 4'd0,
        OP_STOP_SET    = 4'd1,
        OP_STOP_CLEAR  = 4'd2,
        OP_DOOR_OPEN   = 4'd3,
        OP_DOOR_CLOSE  = 4'd4,
        OP_FEED        = 4'd5,
        OP_CLEAN_START = 4'd6,
        OP_CLEAN_STOP  = 4'd7,
        OP_ARM_REQ     = 4'd8,
        OP_SENSOR_FAIL = 4'd9
    } t_op;

    typedef enum logic [5:0] {
        M_BOOT = 6'b000001,
        M_CONN = 6'b000010,
        M_IDLE = 6'b000100,
        M_RUN  = 6'b001000,
        M_ERR  = 6'b010000,
        M_STOP = 6'b100000
    } t_mode;

    typedef struct packed {
        logic [OP_W-1:0]        operation;
        logic                   link_up;
        logic [GRAMS_W-1:0]     feed_grams;
        logic [HEADCOUNT_W-1:0] chicken_count;
    } t_item;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              door_open;
        logic              feed_motor_on;
        logic              clean_motor_on;
        logic              stop_latched;
        logic              arm_vetoed;
        logic              rejected;
        logic              mode_changed;
    } t_result;

    function automatic logic [MODE_W-1:0] mode_code(input t_mode m);
        logic [MODE_W-1:0] c;
        case (m)
            M_BOOT:  c = MODE_CODE_BOOT;
            M_CONN:  c = MODE_CODE_CONN;
            M_IDLE:  c = MODE_CODE_IDLE;
            M_RUN:   c = MODE_CODE_RUN;
            M_ERR:   c = MODE_CODE_ERR;
            M_STOP:  c = MODE_CODE_STOP;
            default: c = MODE_CODE_CONN;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// File: design/asi_if.sv
// valid/ready channel interfaces: command input, result output, register writes
// depends on asi_pkg
`default_nettype none

interface asi_in_if;
    import asi_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [OP_W-1:0]        operation;
    logic                   link_up;
    logic [GRAMS_W-1:0]     feed_grams;
    logic [HEADCOUNT_W-1:0] chicken_count;

    modport source (output valid, operation, link_up, feed_grams, chicken_count,
                    input ready);
    modport sink   (input valid, operation, link_up, feed_grams, chicken_count,
                    output ready);
endinterface

interface asi_out_if;
    import asi_pkg::*;
    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic              door_open;
    logic              feed_motor_on;
    logic              clean_motor_on;
    logic              stop_latched;
    logic              arm_vetoed;
    logic              rejected;
    logic              mode_changed;

    modport source (output valid, mode, door_open, feed_motor_on, clean_motor_on,
                    stop_latched, arm_vetoed, rejected, mode_changed,
                    input ready);
    modport sink   (input valid, mode, door_open, feed_motor_on, clean_motor_on,
                    stop_latched, arm_vetoed, rejected, mode_changed,
                    output ready);
endinterface

interface asi_cfg_if;
    import asi_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: design/asi_ctrl.sv
// interlock state: mode controller, stop latch, door, feed and cleaning countdowns
// depends on asi_pkg; fed one accepted transaction at a time by the top level
`default_nettype none

module asi_ctrl
    import asi_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_accept,
    input  wire t_item                  i_item,
    input  wire logic [FEED_RATE_W-1:0] i_feed_rate,
    input  wire logic [CLEAN_CAP_W-1:0] i_clean_cap,
    output t_result                     o_result
);

    localparam int WIDE_W = (COUNT_WIDTH > FEED_PROD_W) ? COUNT_WIDTH : FEED_PROD_W;
    localparam logic [WIDE_W-1:0] CNT_MAX = WIDE_W'({COUNT_WIDTH{1'b1}});

    t_mode                  r_mode, n_mode;
    logic                   r_stop, n_stop;
    logic                   r_door, n_door;
    logic                   r_feed_active, n_feed_active;
    logic [COUNT_WIDTH-1:0] r_feed_left, n_feed_left;
    logic                   r_clean_active, n_clean_active;
    logic [COUNT_WIDTH-1:0] r_clean_left, n_clean_left;

    logic                   n_vetoed;
    logic                   n_rejected;
    logic [FEED_PROD_W-1:0] feed_prod;
    logic [WIDE_W-1:0]      feed_wide;
    logic [WIDE_W-1:0]      cap_wide;
    logic [COUNT_WIDTH-1:0] feed_sat;
    logic [COUNT_WIDTH-1:0] cap_sat;
    t_op                    op;

    // load values saturated at the counter width
    assign feed_prod = FEED_PROD_W'(i_item.feed_grams) * FEED_PROD_W'(i_feed_rate);
    assign feed_wide = WIDE_W'(feed_prod);
    assign cap_wide  = WIDE_W'(i_clean_cap);
    assign feed_sat  = (feed_wide > CNT_MAX) ? COUNT_WIDTH'(CNT_MAX)
                                             : COUNT_WIDTH'(feed_wide);
    assign cap_sat   = (cap_wide > CNT_MAX) ? COUNT_WIDTH'(CNT_MAX)
                                            : COUNT_WIDTH'(cap_wide);
    assign op        = t_op'(i_item.operation);

    always_comb begin
        n_mode         = r_mode;
        n_stop         = r_stop;
        n_door         = r_door;
        n_feed_active  = r_feed_active;
        n_feed_left    = r_feed_left;
        n_clean_active = r_clean_active;
        n_clean_left   = r_clean_left;
        n_vetoed       = 1'b0;
        n_rejected     = r_stop && (i_item.operation inside {[OP_DOOR_OPEN:OP_SENSOR_FAIL]});

        if (!n_rejected) begin
            case (op)
                OP_TICK: begin
                    // drives count down in every mode
                    if (r_feed_active) begin
                        if (r_feed_left != '0) begin
                            n_feed_left = r_feed_left - COUNT_WIDTH'(1);
                        end
                        n_feed_active = (n_feed_left != '0);
                    end
                    if (r_clean_active) begin
                        if (r_clean_left != '0) begin
                            n_clean_left = r_clean_left - COUNT_WIDTH'(1);
                        end
                        n_clean_active = (n_clean_left != '0);
                    end
                    n_mode = r_stop ? M_STOP : r_mode;
                    case (n_mode)
                        M_BOOT: begin
                            n_mode = M_CONN;
                        end
                        M_CONN: begin
                            if (i_item.link_up) begin
                                n_mode = (n_feed_active || n_clean_active) ? M_RUN : M_IDLE;
                            end
                        end
                        M_IDLE: begin
                            if (!i_item.link_up) begin
                                n_mode = M_CONN;
                            end
                        end
                        M_RUN: begin
                            if (!i_item.link_up) begin
                                n_mode = M_CONN;
                            end else if (!n_feed_active && !n_clean_active) begin
                                n_mode = M_IDLE;
                            end
                        end
                        M_ERR: begin
                            if (i_item.link_up) begin
                                n_mode = M_IDLE;
                            end
                        end
                        M_STOP: begin
                            n_feed_active  = 1'b0;
                            n_clean_active = 1'b0;
                        end
                        default: begin
                            n_mode = M_CONN;
                        end
                    endcase
                end
                OP_STOP_SET: begin
                    n_stop         = 1'b1;
                    n_feed_active  = 1'b0;
                    n_clean_active = 1'b0;
                    n_mode         = M_STOP;
                end
                OP_STOP_CLEAR: begin
                    n_stop = 1'b0;
                    n_mode = M_IDLE;
                end
                OP_DOOR_OPEN: begin
                    n_door = 1'b1;
                end
                OP_DOOR_CLOSE: begin
                    n_door = 1'b0;
                end
                OP_FEED: begin
                    if (i_item.feed_grams != '0) begin
                        n_feed_left   = feed_sat;
                        n_feed_active = 1'b1;
                        n_mode        = M_RUN;
                    end
                end
                OP_CLEAN_START: begin
                    n_clean_left   = cap_sat;
                    n_clean_active = 1'b1;
                    n_mode         = M_RUN;
                end
                OP_CLEAN_STOP: begin
                    n_clean_active = 1'b0;
                end
                OP_ARM_REQ: begin
                    n_vetoed = (i_item.chicken_count != '0);
                end
                OP_SENSOR_FAIL: begin
                    if (r_mode == M_IDLE || r_mode == M_RUN) begin
                        n_feed_active  = 1'b0;
                        n_clean_active = 1'b0;
                        n_mode         = M_ERR;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode         <= M_BOOT;
            r_stop         <= 1'b0;
            r_door         <= 1'b0;
            r_feed_active  <= 1'b0;
            r_feed_left    <= '0;
            r_clean_active <= 1'b0;
            r_clean_left   <= '0;
        end else if (i_accept) begin
            r_mode         <= n_mode;
            r_stop         <= n_stop;
            r_door         <= n_door;
            r_feed_active  <= n_feed_active;
            r_feed_left    <= n_feed_left;
            r_clean_active <= n_clean_active;
            r_clean_left   <= n_clean_left;
        end
    end

    always_comb begin
        o_result.mode           = mode_code(n_mode);
        o_result.door_open      = n_door;
        o_result.feed_motor_on  = n_feed_active;
        o_result.clean_motor_on = n_clean_active;
        o_result.stop_latched   = n_stop;
        o_result.arm_vetoed     = n_vetoed;
        o_result.rejected       = n_rejected;
        o_result.mode_changed   = (n_mode != r_mode);
    end

`ifndef ASSERT_OFF
    a_stop_mode : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stop |-> (r_mode == M_STOP))
        else $error("stop latched outside estop mode");

    a_halt_no_drive : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == M_ERR || r_mode == M_STOP) |-> (!r_feed_active && !r_clean_active))
        else $error("drive active in error or estop mode");

    a_reject_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && n_rejected) |=> ($stable(r_mode) && $stable(r_door)
                                      && $stable(r_feed_active) && $stable(r_clean_active)))
        else $error("rejected transaction changed state");
`endif

endmodule

`default_nettype wire

// File: design/actuator_safety_interlock_top.sv
// output: each accepted transaction's result is registered and presented from the result register
// throughput: one transaction per cycle; the single result register is refilled
//   in the same cycle that it is taken, so input ready drops only on output stall
// reset: synchronous active-low i_rst_n returns boot mode, stop clear, door closed,
//   drives off, registers to 30 ms per gram and 300000 ms cleaning cap
// depends on asi_pkg, asi_if and asi_ctrl
`default_nettype none

module actuator_safety_interlock_top
    import asi_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    asi_in_if.sink     i_in,
    asi_out_if.source  o_out,
    asi_cfg_if.sink    i_cfg
);

    logic [FEED_RATE_W-1:0] r_feed_rate;
    logic [CLEAN_CAP_W-1:0] r_clean_cap;
    logic                   r_out_valid;
    t_result                r_out;
    t_result                n_out;
    t_item                  item;
    logic                   accept;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_feed_rate <= FEED_RATE_RST;
            r_clean_cap <= CLEAN_CAP_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_FEED_RATE: r_feed_rate <= i_cfg.data[FEED_RATE_W-1:0];
                CFG_CLEAN_CAP: r_clean_cap <= i_cfg.data[CLEAN_CAP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign accept     = i_in.valid && i_in.ready;

    assign item.operation     = i_in.operation;
    assign item.link_up       = i_in.link_up;
    assign item.feed_grams    = i_in.feed_grams;
    assign item.chicken_count = i_in.chicken_count;

    asi_ctrl #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_item      (item),
        .i_feed_rate (r_feed_rate),
        .i_clean_cap (r_clean_cap),
        .o_result    (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.mode           = r_out.mode;
    assign o_out.door_open      = r_out.door_open;
    assign o_out.feed_motor_on  = r_out.feed_motor_on;
    assign o_out.clean_motor_on = r_out.clean_motor_on;
    assign o_out.stop_latched   = r_out.stop_latched;
    assign o_out.arm_vetoed     = r_out.arm_vetoed;
    assign o_out.rejected       = r_out.rejected;
    assign o_out.mode_changed   = r_out.mode_changed;

`ifndef ASSERT_OFF
    a_accept_fills : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_out_valid)
        else $error("accepted transaction left no result");

    a_stall_blocks : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_out.ready) |-> !i_in.ready)
        else $error("input taken while result register stalled");

    a_drain : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && o_out.ready && !accept) |=> !r_out_valid)
        else $error("taken result not released");
`endif

endmodule

`default_nettype wire

// File: tb/testbench.sv
// self-checking testbench for actuator_safety_interlock_top: random and directed transactions
// are checked field by field against a built-in predictor held in a scoreboard class
// depends on asi_pkg, asi_if and the design sources
`default_nettype none

module testbench;
    import asi_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CNT_W = COUNT_WIDTH_DEF;
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = CFG_IDX_W'(15);
    localparam logic [OP_W-1:0] OP_UNUSED_LO = OP_W'(10);
    localparam logic [OP_W-1:0] OP_UNUSED_HI = OP_W'(15);

    class interlock_scoreboard;
        logic [FEED_RATE_W-1:0] rate_q;
        logic [CLEAN_CAP_W-1:0] cap_q;
        logic [MODE_W-1:0]      mode_q;
        bit                     stop_q;
        bit                     door_q;
        bit                     feed_on;
        bit                     clean_on;
        logic [CNT_W-1:0]       feed_cnt;
        logic [CNT_W-1:0]       clean_cnt;
        t_result                expected_results[$];
        int                     errors;

        function new();
            rate_q    = FEED_RATE_RST;
            cap_q     = CLEAN_CAP_RST;
            mode_q    = MODE_CODE_BOOT;
            stop_q    = 0;
            door_q    = 0;
            feed_on   = 0;
            clean_on  = 0;
            feed_cnt  = '0;
            clean_cnt = '0;
            errors    = 0;
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_FEED_RATE) begin
                rate_q = data[FEED_RATE_W-1:0];
            end else if (idx == CFG_CLEAN_CAP) begin
                cap_q = data[CLEAN_CAP_W-1:0];
            end
        endfunction

        function logic [CNT_W-1:0] saturate(longint unsigned v);
            longint unsigned lim;
            lim = (64'd1 << CNT_W) - 1;
            return (v > lim) ? CNT_W'(lim) : CNT_W'(v);
        endfunction

        function void count_down(ref bit on, ref logic [CNT_W-1:0] cnt);
            if (!on) return;
            if (cnt != 0) cnt = cnt - 1'b1;
            if (cnt == 0) on = 0;
        endfunction

        function void advance_tick(bit link);
            count_down(feed_on, feed_cnt);
            count_down(clean_on, clean_cnt);
            if (stop_q && mode_q != MODE_CODE_STOP) mode_q = MODE_CODE_STOP;
            case (mode_q)
                MODE_CODE_BOOT: mode_q = MODE_CODE_CONN;
                MODE_CODE_CONN: begin
                    if (link) mode_q = (feed_on || clean_on) ? MODE_CODE_RUN : MODE_CODE_IDLE;
                end
                MODE_CODE_IDLE: begin
                    if (!link) mode_q = MODE_CODE_CONN;
                end
                MODE_CODE_RUN: begin
                    if (!feed_on && !clean_on) mode_q = MODE_CODE_IDLE;
                    if (!link) mode_q = MODE_CODE_CONN;
                end
                MODE_CODE_ERR: begin
                    if (link) mode_q = MODE_CODE_IDLE;
                end
                MODE_CODE_STOP: begin
                    feed_on  = 0;
                    clean_on = 0;
                end
                default: mode_q = MODE_CODE_CONN;
            endcase
        endfunction

        function void note_command(t_item cmd);
            t_result           res;
            logic [MODE_W-1:0] prev_mode;
            bit                vetoed;
            bit                refused;
            prev_mode = mode_q;
            vetoed    = 0;
            refused   = 0;
            if (cmd.operation >= OP_DOOR_OPEN && cmd.operation <= OP_SENSOR_FAIL && stop_q) begin
                refused = 1;
            end else begin
                case (cmd.operation)
                    OP_TICK: advance_tick(cmd.link_up);
                    OP_STOP_SET: begin
                        stop_q   = 1;
                        feed_on  = 0;
                        clean_on = 0;
                        mode_q   = MODE_CODE_STOP;
                    end
                    OP_STOP_CLEAR: begin
                        stop_q = 0;
                        mode_q = MODE_CODE_IDLE;
                    end
                    OP_DOOR_OPEN:  door_q = 1;
                    OP_DOOR_CLOSE: door_q = 0;
                    OP_FEED: begin
                        if (cmd.feed_grams != 0) begin
                            feed_cnt = saturate(longint'(cmd.feed_grams) * longint'(rate_q));
                            feed_on  = 1;
                            mode_q   = MODE_CODE_RUN;
                        end
                    end
                    OP_CLEAN_START: begin
                        clean_cnt = saturate(longint'(cap_q));
                        clean_on  = 1;
                        mode_q    = MODE_CODE_RUN;
                    end
                    OP_CLEAN_STOP: clean_on = 0;
                    OP_ARM_REQ:    vetoed = (cmd.chicken_count != 0);
                    OP_SENSOR_FAIL: begin
                        if (mode_q == MODE_CODE_IDLE || mode_q == MODE_CODE_RUN) begin
                            feed_on  = 0;
                            clean_on = 0;
                            mode_q   = MODE_CODE_ERR;
                        end
                    end
                    default: ;
                endcase
            end
            res.mode           = mode_q;
            res.door_open      = door_q;
            res.feed_motor_on  = feed_on;
            res.clean_motor_on = clean_on;
            res.stop_latched   = stop_q;
            res.arm_vetoed     = vetoed;
            res.rejected       = refused;
            res.mode_changed   = (mode_q != prev_mode);
            expected_results.push_back(res);
        endfunction

        function void compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
            if (act_v !== exp_v) begin
                $error("%s expected %0d actual %0d", name, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check_result(t_result got);
            t_result exp_r;
            if (expected_results.size() == 0) begin
                $error("result transaction with no pending expectation");
                errors++;
                return;
            end
            exp_r = expected_results.pop_front();
            compare_field("mode", 32'(exp_r.mode), 32'(got.mode));
            compare_field("door_open", 32'(exp_r.door_open), 32'(got.door_open));
            compare_field("feed_motor_on", 32'(exp_r.feed_motor_on), 32'(got.feed_motor_on));
            compare_field("clean_motor_on", 32'(exp_r.clean_motor_on),
                          32'(got.clean_motor_on));
            compare_field("stop_latched", 32'(exp_r.stop_latched), 32'(got.stop_latched));
            compare_field("arm_vetoed", 32'(exp_r.arm_vetoed), 32'(got.arm_vetoed));
            compare_field("rejected", 32'(exp_r.rejected), 32'(got.rejected));
            compare_field("mode_changed", 32'(exp_r.mode_changed), 32'(got.mode_changed));
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    int   src_idle_pct;
    int   sink_stall_pct;

    interlock_scoreboard sb;

    asi_in_if  in_ch ();
    asi_out_if out_ch ();
    asi_cfg_if cfg_ch ();

    actuator_safety_interlock_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

    initial begin
        t_result got;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            out_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
            @(posedge i_clk);
            if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
                got.mode           = out_ch.mode;
                got.door_open      = out_ch.door_open;
                got.feed_motor_on  = out_ch.feed_motor_on;
                got.clean_motor_on = out_ch.clean_motor_on;
                got.stop_latched   = out_ch.stop_latched;
                got.arm_vetoed     = out_ch.arm_vetoed;
                got.rejected       = out_ch.rejected;
                got.mode_changed   = out_ch.mode_changed;
                sb.check_result(got);
            end
        end
    end

    function automatic t_item make_cmd(logic [OP_W-1:0] op, logic link,
                                       logic [GRAMS_W-1:0] grams,
                                       logic [HEADCOUNT_W-1:0] heads);
        t_item c;
        c.operation     = op;
        c.link_up       = link;
        c.feed_grams    = grams;
        c.chicken_count = heads;
        return c;
    endfunction

    function automatic t_item random_command();
        t_item       c;
        int unsigned pick;
        int unsigned sel;
        pick = $urandom_range(99);
        c.link_up       = ($urandom_range(99) < 85);
        c.chicken_count = $urandom_range(1) ? '0 : HEADCOUNT_W'($urandom);
        c.feed_grams    = GRAMS_W'($urandom);
        if (pick < 40)      c.operation = OP_TICK;
        else if (pick < 44) c.operation = OP_STOP_SET;
        else if (pick < 52) c.operation = OP_STOP_CLEAR;
        else if (pick < 57) c.operation = OP_DOOR_OPEN;
        else if (pick < 62) c.operation = OP_DOOR_CLOSE;
        else if (pick < 72) begin
            c.operation = OP_FEED;
            sel = $urandom_range(19);
            if (sel == 0)      c.feed_grams = '0;
            else if (sel == 1) c.feed_grams = GRAMS_W'($urandom);
            else               c.feed_grams = GRAMS_W'($urandom_range(6, 1));
        end
        else if (pick < 78) c.operation = OP_CLEAN_START;
        else if (pick < 83) c.operation = OP_CLEAN_STOP;
        else if (pick < 90) c.operation = OP_ARM_REQ;
        else if (pick < 94) c.operation = OP_SENSOR_FAIL;
        else                c.operation = OP_W'($urandom_range(OP_UNUSED_HI, OP_UNUSED_LO));
        return c;
    endfunction

    task automatic send_command(input t_item cmd);
        while ($urandom_range(99) < src_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.operation     <= cmd.operation;
        in_ch.link_up       <= cmd.link_up;
        in_ch.feed_grams    <= cmd.feed_grams;
        in_ch.chicken_count <= cmd.chicken_count;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        sb.note_command(cmd);
        @(negedge i_clk);
    endtask

    task automatic wait_results();
        in_ch.valid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (3) @(negedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do @(posedge i_clk); while (cfg_ch.ready !== 1'b1);
        sb.write_register(idx, data);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic run_phase(input int rate, input int cap, input int idle_pct,
                             input int stall_pct, input int count, input bit hold_off);
        wait_results();
        write_register(CFG_FEED_RATE,
                       {(CFG_DATA_W-FEED_RATE_W)'($urandom), FEED_RATE_W'(rate)});
        write_register(CFG_CLEAN_CAP, CFG_DATA_W'(cap));
        src_idle_pct   = idle_pct;
        sink_stall_pct = stall_pct;
        for (int k = 0; k < count; k++) begin
            if (hold_off && k == count / 2) wait_results();
            send_command(random_command());
        end
    endtask

    task automatic directed_part();
        send_command(make_cmd(OP_TICK, 1'b0, '0, '0));
        send_command(make_cmd(OP_TICK, 1'b0, '0, '0));
        send_command(make_cmd(OP_TICK, 1'b1, '0, '0));
        send_command(make_cmd(OP_ARM_REQ, 1'b1, '0, '0));
        send_command(make_cmd(OP_ARM_REQ, 1'b1, '0, '1));
        send_command(make_cmd(OP_DOOR_OPEN, 1'b1, '0, '0));
        send_command(make_cmd(OP_DOOR_CLOSE, 1'b1, '0, '0));
        send_command(make_cmd(OP_FEED, 1'b1, '0, '0));
        send_command(make_cmd(OP_FEED, 1'b1, '1, '1));
        send_command(make_cmd(OP_TICK, 1'b1, '1, '1));
        send_command(make_cmd(OP_CLEAN_START, 1'b1, '0, '0));
        send_command(make_cmd(OP_CLEAN_STOP, 1'b1, '0, '0));
        send_command(make_cmd(OP_TICK, 1'b0, '0, '0));
        send_command(make_cmd(OP_TICK, 1'b1, '0, '0));
        send_command(make_cmd(OP_SENSOR_FAIL, 1'b1, '0, '0));
        send_command(make_cmd(OP_SENSOR_FAIL, 1'b1, '0, '0));
        send_command(make_cmd(OP_TICK, 1'b1, '0, '0));
        send_command(make_cmd(OP_UNUSED_HI, 1'b1, '1, '1));
        send_command(make_cmd(OP_UNUSED_LO, 1'b0, '0, '0));
        send_command(make_cmd(OP_STOP_SET, 1'b1, '0, '0));
        send_command(make_cmd(OP_DOOR_OPEN, 1'b1, '0, '0));
        send_command(make_cmd(OP_FEED, 1'b1, GRAMS_W'(5), '0));
        send_command(make_cmd(OP_TICK, 1'b1, '0, '0));
        send_command(make_cmd(OP_STOP_SET, 1'b0, '0, '0));
        send_command(make_cmd(OP_STOP_CLEAR, 1'b0, '0, '0));
        send_command(make_cmd(OP_TICK, 1'b1, '0, '0));
    endtask

    initial begin
        sb = new();
        i_rst_n             = 1'b0;
        in_ch.valid         = 1'b0;
        in_ch.operation     = '0;
        in_ch.link_up       = 1'b0;
        in_ch.feed_grams    = '0;
        in_ch.chicken_count = '0;
        out_ch.ready        = 1'b0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.index        = '0;
        cfg_ch.data         = '0;
        src_idle_pct        = 0;
        sink_stall_pct      = 0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        directed_part();

        run_phase(1, 6, 0, 0, 140, 1'b0);
        run_phase(2, 40, 72, 0, 140, 1'b0);
        run_phase(255, 1048575, 0, 72, 140, 1'b0);
        run_phase(0, 0, 23, 23, 140, 1'b0);
        wait_results();
        write_register(CFG_UNMAPPED, CFG_DATA_W'($urandom));
        run_phase(1, 1, 0, 0, 140, 1'b0);
        run_phase(5, 25, 72, 0, 140, 1'b1);
        run_phase(3, 12, 0, 72, 140, 1'b0);
        run_phase(1, 100, 23, 23, 140, 1'b0);

        wait_results();
        repeat (5) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

`default_nettype wire
